// ===== src/nnrc_pkg.sv =====
// Shared constants, types and the distance function of the nearest neighbor radius classifier.
`timescale 1ns / 1ps
`default_nettype none
package nnrc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int POINT_W    = 3 * COORD_W;
	localparam int DIST_W     = 18;
	localparam int INDEX_W    = 6;
	localparam int CLASS_W    = 2;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

	localparam logic [CLASS_W-1:0] CLASS_128 = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_256 = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_512 = 2'd2;

	localparam logic [DIST_W-1:0] DIST_256 = DIST_W'(256);
	localparam logic [DIST_W-1:0] DIST_128 = DIST_W'(128);

	typedef logic [POINT_W-1:0] point_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] rd_addr;
		logic             latch_i;
		logic             clr_best;
		logic             cmp;
		logic             emit;
		logic             last;
		logic [CNT_W-1:0] index;
	} nnrc_cmd_t;

	typedef struct packed {
		logic out_free;
	} nnrc_stat_t;

	function automatic logic [COORD_W-1:0] nnrc_abs_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [DIST_W-1:0] nnrc_dist(input point_t a, input point_t b);
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [COORD_W-1:0] dz;
		logic [DIST_W-1:0]  m;
		logic [DIST_W-1:0]  wz;
		dx = nnrc_abs_diff(a[COORD_W-1:0], b[COORD_W-1:0]);
		dy = nnrc_abs_diff(a[2*COORD_W-1:COORD_W], b[2*COORD_W-1:COORD_W]);
		dz = nnrc_abs_diff(a[3*COORD_W-1:2*COORD_W], b[3*COORD_W-1:2*COORD_W]);
		m  = DIST_W'((dx > dy) ? dx : dy);
		wz = {dz, 2'b00};
		return (m > wz) ? m : wz;
	endfunction

endpackage
`default_nettype wire

// ===== src/nnrc_if.sv =====
// Valid/ready channel interfaces for point beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface nnrc_point_if;
	logic        valid;
	logic        ready;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] pos_z;
	logic        final_point;

	modport source(output valid, output pos_x, output pos_y, output pos_z,
		output final_point, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z,
		input final_point, output ready);
endinterface

interface nnrc_result_if;
	logic        valid;
	logic        ready;
	logic [5:0]  point_index;
	logic [17:0] nearest_distance;
	logic [1:0]  radius_class;
	logic        no_neighbor;
	logic        last_result;

	modport source(output valid, output point_index, output nearest_distance,
		output radius_class, output no_neighbor, output last_result, input ready);
	modport sink(input valid, input point_index, input nearest_distance,
		input radius_class, input no_neighbor, input last_result, output ready);
endinterface
`default_nettype wire

// ===== src/nearest_neighbor_radius_class_core.sv =====
// Top level of the nearest neighbor radius classifier.
//
// Points arrive on the pt channel, one beat per point, and are stored in load
// order. A beat with final_point set is stored too (if room remains) and starts
// the run; pt.ready stays low until the run is over. The res channel then gives
// one beat per stored point, in load order, with last_result on the final one.
// For each point the whole store is read once through the single read port of
// the point memory, one entry per cycle, while the controller steps through its
// fetch, latch, scan, flush and emit states. Loading beats are written straight
// into the store as they are accepted.
// Results sit in an output register: a stalled receiver holds the current beat
// and the next result waits in the emit state until it is taken; the last beat
// may wait while the next set loads. Reset empties the store and clears valid.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_radius_class_core import nnrc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	nnrc_point_if.sink     pt,
	nnrc_result_if.source  res
);
	nnrc_cmd_t  cmd;
	nnrc_stat_t stat;

	nnrc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pt.valid),
		.in_final(pt.final_point),
		.in_ready(pt.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	nnrc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.pos_x           (pt.pos_x),
		.pos_y           (pt.pos_y),
		.pos_z           (pt.pos_z),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.point_index     (res.point_index),
		.nearest_distance(res.nearest_distance),
		.radius_class    (res.radius_class),
		.no_neighbor     (res.no_neighbor),
		.last_result     (res.last_result)
	);
endmodule
`default_nettype wire

// ===== src/nnrc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nnrc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

// ===== src/nnrc_ctrl.sv =====
// Controller state machine: point loading, the all-pairs scan and result issue.
`timescale 1ns / 1ps
`default_nettype none
module nnrc_ctrl import nnrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_final,
	output logic       in_ready,
	input  nnrc_stat_t stat,
	output nnrc_cmd_t  cmd
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FETCH = 6'b000010,
		ST_LATCH = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_FLUSH = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic             last_i;

	assign last_i = ((i_q + CNT_W'(1)) == count_q);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		i_d          = i_q;
		j_d          = j_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.wr_addr  = count_q[IDX_W-1:0];
		cmd.rd_addr  = j_q[IDX_W-1:0];
		cmd.index    = i_q;
		cmd.last     = last_i;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (count_q < MAX_CNT) begin
						cmd.wr_en = 1'b1;
						count_d   = count_q + CNT_W'(1);
					end
					if (in_final) begin
						i_d     = '0;
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.rd_addr = i_q[IDX_W-1:0];
				state_d     = ST_LATCH;
			end
			ST_LATCH: begin
				cmd.latch_i  = 1'b1;
				cmd.clr_best = 1'b1;
				cmd.rd_addr  = '0;
				j_d          = CNT_W'(1);
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.cmp = 1'b1;
				if (j_q == count_q) begin
					state_d = ST_FLUSH;
				end else begin
					j_d = j_q + CNT_W'(1);
				end
			end
			ST_FLUSH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (last_i) begin
						count_d = '0;
						state_d = ST_IDLE;
					end else begin
						i_d     = i_q + CNT_W'(1);
						state_d = ST_FETCH;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end
endmodule
`default_nettype wire

// ===== src/nnrc_dp.sv =====
// Datapath: point store, distance stage, running minimum and the result register.
`timescale 1ns / 1ps
`default_nettype none
module nnrc_dp import nnrc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [COORD_W-1:0]  pos_x,
	input  logic [COORD_W-1:0]  pos_y,
	input  logic [COORD_W-1:0]  pos_z,
	input  nnrc_cmd_t           cmd,
	output nnrc_stat_t          stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [INDEX_W-1:0]  point_index,
	output logic [DIST_W-1:0]   nearest_distance,
	output logic [CLASS_W-1:0]  radius_class,
	output logic                no_neighbor,
	output logic                last_result
);
	point_t            rd_data;
	point_t            pi_q;
	logic [DIST_W-1:0] dist_s1;
	logic              skip_s1;
	logic              vld_s1;
	logic [DIST_W-1:0] best_q;
	logic              found_q;
	logic              out_valid_q;

	nnrc_ram #(
		.WIDTH(POINT_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(cmd.wr_addr),
		.wr_data({pos_z, pos_y, pos_x}),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_i) begin
			pi_q <= rd_data;
		end
		dist_s1 <= nnrc_dist(pi_q, rd_data);
		skip_s1 <= (pi_q == rd_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.cmp;
			if (cmd.clr_best) begin
				found_q <= 1'b0;
			end else if (vld_s1 && !skip_s1 && (!found_q || dist_s1 < best_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.clr_best && vld_s1 && !skip_s1 && (!found_q || dist_s1 < best_q)) begin
			best_q <= dist_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_index <= INDEX_W'(cmd.index);
			last_result <= cmd.last;
			no_neighbor <= !found_q;
			if (found_q) begin
				nearest_distance <= best_q;
				if (best_q >= DIST_256) begin
					radius_class <= CLASS_512;
				end else if (best_q >= DIST_128) begin
					radius_class <= CLASS_256;
				end else begin
					radius_class <= CLASS_128;
				end
			end else begin
				nearest_distance <= '0;
				radius_class     <= CLASS_512;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ===== src/nnrc_checker.sv =====
// Port-level checks of the classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nnrc_checker import nnrc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               in_final,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [INDEX_W-1:0] point_index,
	input wire logic [DIST_W-1:0]  nearest_distance,
	input wire logic [CLASS_W-1:0] radius_class,
	input wire logic               no_neighbor
);
	// A stalled result beat stays on the port with its index and distance unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_index)
			&& $stable(nearest_distance))
		else $error("result beat changed while stalled");

	// A final point closes the input until the run is done.
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_final |=> !in_ready)
		else $error("input open right after a final point");

	// New results are only produced while the input is closed.
	a_emit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> !$past(in_ready))
		else $error("result issued while loading");

	// A point without a distinct neighbor reports zero distance and the top class.
	a_no_neighbor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_neighbor |-> nearest_distance == '0 && radius_class == CLASS_512)
		else $error("inconsistent no-neighbor result");
endmodule

bind nearest_neighbor_radius_class_core nnrc_checker u_nnrc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (pt.valid),
	.in_ready        (pt.ready),
	.in_final        (pt.final_point),
	.out_valid       (res.valid),
	.out_ready       (res.ready),
	.point_index     (res.point_index),
	.nearest_distance(res.nearest_distance),
	.radius_class    (res.radius_class),
	.no_neighbor     (res.no_neighbor)
);
`default_nettype wire

// ===== tb/nearest_neighbor_radius_class_core_tb.sv =====
// Self-checking testbench for the nearest neighbor radius classifier core.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_radius_class_core_tb;
	import nnrc_pkg::*;

	localparam int RANDOM_ITEMS = 140;
	localparam int RADIUS_WIDE  = 512;
	localparam int RADIUS_MID   = 256;

	typedef struct packed {
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} voxel_t;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [DIST_W-1:0]  reach;
		logic [CLASS_W-1:0] cls;
		logic               none;
		logic               last;
	} radius_result_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               fin;
		logic               typed;
		logic [DIST_W-1:0]  reach;
		logic [CLASS_W-1:0] cls;
		logic               none;
	} stim_row_t;

	localparam int DIRECTED_N = 21;
	localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
		'{16'd0,     16'd0,     16'd0,     1'b1, 1'b1, 18'd0,      CLASS_512, 1'b1},
		'{16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b1, 18'd262140, CLASS_512, 1'b0},
		'{16'd65535, 16'd0,     16'd65535, 1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd65535, 16'd0,     16'd65535, 1'b1, 1'b1, 18'd0,      CLASS_512, 1'b1},
		'{16'd100,   16'd200,   16'd300,   1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd227,   16'd200,   16'd300,   1'b1, 1'b1, 18'd127,    CLASS_128, 1'b0},
		'{16'd100,   16'd200,   16'd300,   1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd100,   16'd328,   16'd300,   1'b1, 1'b1, 18'd128,    CLASS_256, 1'b0},
		'{16'd0,     16'd65535, 16'd0,     1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd255,   16'd65535, 16'd0,     1'b1, 1'b1, 18'd255,    CLASS_256, 1'b0},
		'{16'd9,     16'd9,     16'd9,     1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd9,     16'd9,     16'd73,    1'b1, 1'b1, 18'd256,    CLASS_512, 1'b0},
		'{16'd40000, 16'd40000, 16'd1000,  1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd40000, 16'd40000, 16'd1000,  1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd40001, 16'd40000, 16'd1000,  1'b1, 1'b1, 18'd1,      CLASS_128, 1'b0},
		'{16'd1000,  16'd2000,  16'd3000,  1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd1100,  16'd2050,  16'd3010,  1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd700,   16'd2000,  16'd3000,  1'b0, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd1000,  16'd2000,  16'd3031,  1'b1, 1'b0, 18'd0,      CLASS_128, 1'b0},
		'{16'd0,     16'd0,     16'd65535, 1'b1, 1'b1, 18'd0,      CLASS_512, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n;

	nnrc_point_if  pt();
	nnrc_result_if res();

	nearest_neighbor_radius_class_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt),
		.res    (res)
	);

	voxel_t         loaded_points[$];
	radius_result_t pending_results[$];
	int             errors = 0;
	int             beats_sent = 0;
	int             beats_dropped = 0;
	int             sets_run = 0;
	int             results_checked = 0;
	int             lonely_points = 0;
	int             drains = 0;
	int             tx_calm = 0;
	int             rx_calm = 0;
	int             rx_wait = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		else if (r < 85) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 12);
		else return $urandom_range(20, 40);
	endfunction

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic int axis_gap(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// Stores one point and, when the beat closes the set, queues one result per stored point.
	function automatic void load_point(input voxel_t p, input bit fin);
		radius_result_t r;
		int             best;
		int             d;
		int             n;
		bit             found;
		if (loaded_points.size() < MAX_POINTS) loaded_points = {loaded_points, p};
		else beats_dropped++;
		if (!fin) return;
		n = loaded_points.size();
		for (int i = 0; i < n; i++) begin
			found = 1'b0;
			best = 0;
			for (int j = 0; j < n; j++) begin
				if (loaded_points[j] == loaded_points[i]) continue;
				d = axis_gap(loaded_points[i].x, loaded_points[j].x);
				if (axis_gap(loaded_points[i].y, loaded_points[j].y) > d)
					d = axis_gap(loaded_points[i].y, loaded_points[j].y);
				if (4 * axis_gap(loaded_points[i].z, loaded_points[j].z) > d)
					d = 4 * axis_gap(loaded_points[i].z, loaded_points[j].z);
				if (!found || d < best) begin
					best = d;
					found = 1'b1;
				end
			end
			r.idx = INDEX_W'(i);
			r.last = (i == n - 1);
			r.none = !found;
			if (found) begin
				r.reach = DIST_W'(best);
				if (2 * best >= RADIUS_WIDE) r.cls = CLASS_512;
				else if (2 * best >= RADIUS_MID) r.cls = CLASS_256;
				else r.cls = CLASS_128;
			end else begin
				r.reach = '0;
				r.cls = CLASS_512;
				lonely_points++;
			end
			pending_results = {pending_results, r};
		end
		loaded_points.delete();
		sets_run++;
	endfunction

	task automatic send_point(input voxel_t p, input bit fin);
		int gap;
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			pt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt.valid       <= 1'b1;
		pt.pos_x       <= p.x;
		pt.pos_y       <= p.y;
		pt.pos_z       <= p.z;
		pt.final_point <= fin;
		do @(posedge clk); while (pt.ready !== 1'b1);
		load_point(p, fin);
		beats_sent++;
	endtask

	task automatic drain_results();
		pt.valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
		drains++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			res.ready <= 1'b0;
			rx_wait--;
		end else begin
			res.ready <= 1'b1;
			if (rx_calm > 0) begin
				rx_calm--;
			end else begin
				rx_wait = idle_len();
				if ($urandom_range(0, 19) == 0) rx_calm = $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin : check_results
		radius_result_t got;
		radius_result_t want;
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			got = {res.point_index, res.nearest_distance, res.radius_class,
				res.no_neighbor, res.last_result};
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result beat idx=%0d dist=%0d cls=%0d",
					got.idx, got.reach, got.cls));
			end else begin
				want = pending_results.pop_front();
				if (got.idx !== want.idx || got.reach !== want.reach || got.cls !== want.cls
					|| got.none !== want.none || got.last !== want.last) begin
					flag_error($sformatf({"result mismatch: expected idx=%0d dist=%0d cls=%0d ",
						"none=%0b last=%0b, got idx=%0d dist=%0d cls=%0d none=%0b last=%0b"},
						want.idx, want.reach, want.cls, want.none, want.last,
						got.idx, got.reach, got.cls, got.none, got.last));
				end
			end
			results_checked++;
		end
	end

	initial begin
		#500_000;
		$display("FAIL nearest_neighbor_radius_class_core");
		$finish;
	end

	initial begin
		voxel_t         p;
		voxel_t         base;
		voxel_t         set_points[$];
		radius_result_t fix;
		int             rand_items;
		int             n;
		int             kind;
		int             r;
		bit             full_done;

		arst_n         <= 1'b0;
		pt.valid       <= 1'b0;
		pt.pos_x       <= '0;
		pt.pos_y       <= '0;
		pt.pos_z       <= '0;
		pt.final_point <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_N; k++) begin
			p.x = DIRECTED_ROWS[k].x;
			p.y = DIRECTED_ROWS[k].y;
			p.z = DIRECTED_ROWS[k].z;
			send_point(p, DIRECTED_ROWS[k].fin);
			if (DIRECTED_ROWS[k].typed) begin
				fix = pending_results.pop_back();
				fix.reach = DIRECTED_ROWS[k].reach;
				fix.cls   = DIRECTED_ROWS[k].cls;
				fix.none  = DIRECTED_ROWS[k].none;
				pending_results = {pending_results, fix};
			end
		end
		drain_results();

		rand_items = 0;
		full_done = 1'b0;
		while (rand_items < RANDOM_ITEMS) begin
			set_points.delete();
			if (!full_done && rand_items >= 50) begin
				// Overfill the store so that the tail of the set, final beat included, is dropped.
				drain_results();
				n = MAX_POINTS + $urandom_range(1, 3);
				for (int k = 0; k < n; k++) begin
					p.x = 16'($urandom);
					p.y = 16'($urandom);
					p.z = 16'($urandom);
					if (k > 0 && $urandom_range(0, 7) == 0)
						p = set_points[$urandom_range(0, set_points.size() - 1)];
					set_points = {set_points, p};
					send_point(p, k == n - 1);
				end
				full_done = 1'b1;
			end else begin
				kind = $urandom_range(0, 9);
				n = (kind == 0) ? 1 : $urandom_range(2, 8);
				base.x = 16'($urandom);
				base.y = 16'($urandom);
				base.z = 16'($urandom);
				for (int k = 0; k < n; k++) begin
					r = $urandom_range(0, 5);
					if (kind == 1) begin
						p = base;
					end else if (r == 0 && k > 0) begin
						p = set_points[$urandom_range(0, k - 1)];
					end else if (r == 1) begin
						p.x = 16'($urandom);
						p.y = 16'($urandom);
						p.z = 16'($urandom);
					end else begin
						p.x = base.x + 16'($urandom_range(0, 400));
						p.y = base.y + 16'($urandom_range(0, 400));
						p.z = base.z + 16'($urandom_range(0, 100));
					end
					set_points = {set_points, p};
					send_point(p, k == n - 1);
				end
			end
			rand_items += n;
			if ($urandom_range(0, 9) == 0) drain_results();
		end

		pt.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (MAX_POINTS + 8) @(posedge clk);
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_results.size()));

		$display("Run covered %0d point beats in %0d sets, %0d of them dropped on a full store.",
			beats_sent, sets_run, beats_dropped);
		$display("Checked %0d result beats, %0d without a distinct neighbor; %0d full drains.",
			results_checked, lonely_points, drains);
		if (errors == 0) begin
			$display("PASS nearest_neighbor_radius_class_core");
		end else begin
			$display("FAIL nearest_neighbor_radius_class_core");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/nnrc_pkg.sv
src/nnrc_if.sv
src/nnrc_ram.sv
src/nnrc_ctrl.sv
src/nnrc_dp.sv
src/nearest_neighbor_radius_class_core.sv
src/nnrc_checker.sv
tb/nearest_neighbor_radius_class_core_tb.sv
